FILE: design/tlc_pkg.sv
// package: types, constants and register codes for the traffic light controller
package tlc_pkg;

    localparam int ADC_BITS         = 12;
    localparam int TICKS_PER_SECOND = 1000;

    localparam int TIMER_W   = 16;
    localparam int PERIOD_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W   = 7;
    localparam int PHASE_W   = 3;
    localparam int KEY_W     = 2;

    localparam int SEC_MAX = 65535 / TICKS_PER_SECOND;
    localparam int SEC_W   = $clog2(SEC_MAX + 1);
    localparam int SUM_W   = $clog2(2 * SEC_MAX + 1);
    localparam int MS_W    = $clog2(TICKS_PER_SECOND);

    localparam int     RECIP_SHIFT = 17 + $clog2(TICKS_PER_SECOND);
    localparam longint RECIP       = ((64'sd1 <<< RECIP_SHIFT) + TICKS_PER_SECOND - 1)
                                     / TICKS_PER_SECOND;
    localparam int     RECIP_W     = $clog2(RECIP + 1);
    localparam int     PROD_W      = CFG_DATA_W + RECIP_W;

    localparam logic [TIMER_W-1:0]  GREEN_RESET     = 16'd7000;
    localparam logic [TIMER_W-1:0]  YELLOW_RESET    = 16'd3000;
    localparam logic [TIMER_W-1:0]  EMERGENCY_RESET = 16'd10000;
    localparam logic [ADC_BITS-1:0] DARK_RESET      = ADC_BITS'(190);
    localparam logic [PERIOD_W-1:0] SAMPLE_RESET    = 10'd100;
    localparam logic [PERIOD_W-1:0] FLASH_RESET     = 10'd500;

    localparam logic [SEC_W-1:0] GREEN_SECS_RESET  = SEC_W'(7000 / TICKS_PER_SECOND);
    localparam logic [SEC_W-1:0] YELLOW_SECS_RESET = SEC_W'(3000 / TICKS_PER_SECOND);

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd99;

    localparam logic [CFG_IDX_W-1:0] CFG_GREEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH     = 3'd5;

    localparam logic [KEY_W-1:0] KEY_EMERGENCY = 2'd1;
    localparam logic [KEY_W-1:0] KEY_NIGHT     = 2'd2;

    localparam logic [PHASE_W-1:0] PH_A_GREEN  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_A_YELLOW = 3'd1;
    localparam logic [PHASE_W-1:0] PH_B_GREEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_B_YELLOW = 3'd3;
    localparam logic [PHASE_W-1:0] PH_EMERG    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_NIGHT    = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]    key_code;
        logic [ADC_BITS-1:0] light_level;
    } tlc_in_t;

    typedef struct packed {
        logic               lamp_a_green;
        logic               lamp_a_yellow;
        logic               lamp_a_red;
        logic               lamp_b_green;
        logic               lamp_b_yellow;
        logic               lamp_b_red;
        logic [COUNT_W-1:0] seconds_left_a;
        logic [COUNT_W-1:0] seconds_left_b;
        logic               display_blank;
        logic               buzzer_request;
        logic [PHASE_W-1:0] phase;
    } tlc_out_t;

endpackage

FILE: design/traffic_light_controller_unit.sv
// top level: two-road traffic light phase controller, one tick beat per cycle unless stalled
// path: a tick beat goes to the input register, its result to the result register
// throughput: one tick beat per cycle unless the result side stalls, set by the single
// compute stage between the input register and the result register
// reset: async active low, all timers and countdowns cleared, phase A green,
// registers return to their default times
module traffic_light_controller_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tlc_pkg::tlc_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tlc_pkg::tlc_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlc_pkg::*;

    logic [TIMER_W-1:0]  green_reg, yellow_reg, emerg_reg;
    logic [ADC_BITS-1:0] dark_reg;
    logic [PERIOD_W-1:0] sample_period_reg, flash_half_reg;
    logic [SEC_W-1:0]    green_secs_reg, yellow_secs_reg;

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [TIMER_W-1:0]  phase_timer_reg, phase_timer_next;
    logic [MS_W-1:0]     phase_ms_reg, phase_ms_next;
    logic [SEC_W-1:0]    phase_sec_reg, phase_sec_next;
    logic [PERIOD_W-1:0] flash_timer_reg, flash_timer_next;
    logic [PERIOD_W-1:0] sample_timer_reg, sample_timer_next;
    logic                flash_flag_reg, flash_flag_next;
    logic                night_flag_reg, night_flag_next;
    logic [COUNT_W-1:0]  countdown_a_reg, countdown_a_next;
    logic [COUNT_W-1:0]  countdown_b_reg, countdown_b_next;

    logic     s1_valid_reg;
    tlc_in_t  s1_data_reg;
    logic     out_valid_reg;
    tlc_out_t out_data_reg, out_data_next;
    logic     advance;

    logic [PROD_W-1:0] cfg_prod;
    logic [SEC_W-1:0]  cfg_secs;

    function automatic logic [COUNT_W-1:0] secs_left(input logic [SUM_W-1:0] total,
                                                     input logic [SEC_W-1:0] elapsed);
        logic [SUM_W-1:0] r;
        r = (total > SUM_W'(elapsed)) ? total - SUM_W'(elapsed) : '0;
        if (r > SUM_W'(COUNT_MAX))
        begin
            return COUNT_MAX;
        end
        return COUNT_W'(r);
    endfunction

    // divide by ticks per second through a reciprocal
    assign cfg_prod  = PROD_W'(cfg_data) * PROD_W'(RECIP);
    assign cfg_secs  = SEC_W'(cfg_prod >> RECIP_SHIFT);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg         <= GREEN_RESET;
            yellow_reg        <= YELLOW_RESET;
            emerg_reg         <= EMERGENCY_RESET;
            dark_reg          <= DARK_RESET;
            sample_period_reg <= SAMPLE_RESET;
            flash_half_reg    <= FLASH_RESET;
            green_secs_reg    <= GREEN_SECS_RESET;
            yellow_secs_reg   <= YELLOW_SECS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GREEN:
                begin
                    green_reg      <= cfg_data;
                    green_secs_reg <= cfg_secs;
                end
                CFG_YELLOW:
                begin
                    yellow_reg      <= cfg_data;
                    yellow_secs_reg <= cfg_secs;
                end
                CFG_EMERGENCY: emerg_reg         <= cfg_data;
                CFG_DARK:      dark_reg          <= cfg_data[ADC_BITS-1:0];
                CFG_SAMPLE:    sample_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_FLASH:     flash_half_reg    <= cfg_data[PERIOD_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // one tick of the controller
    always_comb
    begin
        logic [PHASE_W-1:0] p;
        logic [TIMER_W-1:0] t;
        logic               tclr;
        logic               nf;
        logic               ff;
        logic               blink;
        logic [SUM_W-1:0]   gs;
        logic [SUM_W-1:0]   ys;

        p    = phase_reg;
        tclr = 1'b0;
        if (s1_data_reg.key_code == KEY_EMERGENCY)
        begin
            p = PH_EMERG;
        end
        else if (s1_data_reg.key_code == KEY_NIGHT)
        begin
            p = PH_NIGHT;
        end

        t                 = phase_timer_reg + 1'b1;
        flash_timer_next  = flash_timer_reg + 1'b1;
        sample_timer_next = sample_timer_reg + 1'b1;
        nf                = night_flag_reg;
        ff                = flash_flag_reg;

        if (sample_timer_next >= sample_period_reg)
        begin
            sample_timer_next = '0;
            nf = (s1_data_reg.light_level < dark_reg);
            if (nf && p != PH_NIGHT)
            begin
                p    = PH_NIGHT;
                t    = '0;
                tclr = 1'b1;
            end
            else if (!nf && p == PH_NIGHT)
            begin
                p    = PH_A_GREEN;
                t    = '0;
                tclr = 1'b1;
            end
        end

        if (flash_timer_next >= flash_half_reg)
        begin
            flash_timer_next = '0;
            ff = !ff;
        end

        // phase chain, a zero length lets a phase pass straight on
        if (!nf)
        begin
            if (p == PH_A_GREEN && t >= green_reg)
            begin
                t = '0; tclr = 1'b1; p = PH_A_YELLOW;
            end
            if (p == PH_A_YELLOW && t >= yellow_reg)
            begin
                t = '0; tclr = 1'b1; p = PH_B_GREEN;
            end
            if (p == PH_B_GREEN && t >= green_reg)
            begin
                t = '0; tclr = 1'b1; p = PH_B_YELLOW;
            end
            if (p == PH_B_YELLOW && t >= yellow_reg)
            begin
                t = '0; tclr = 1'b1; p = PH_A_GREEN;
            end
        end

        if (p == PH_EMERG && t >= emerg_reg)
        begin
            t = '0; tclr = 1'b1; p = PH_A_GREEN;
        end

        // seconds and milliseconds of the phase timer, kept alongside it
        if (tclr || phase_timer_reg == '1)
        begin
            phase_ms_next  = '0;
            phase_sec_next = '0;
        end
        else if (phase_ms_reg == MS_W'(TICKS_PER_SECOND - 1))
        begin
            phase_ms_next  = '0;
            phase_sec_next = phase_sec_reg + 1'b1;
        end
        else
        begin
            phase_ms_next  = phase_ms_reg + 1'b1;
            phase_sec_next = phase_sec_reg;
        end

        gs = SUM_W'(green_secs_reg);
        ys = SUM_W'(yellow_secs_reg);
        countdown_a_next = countdown_a_reg;
        countdown_b_next = countdown_b_reg;
        if (phase_ms_next == MS_W'(1))
        begin
            if (p == PH_A_GREEN)
            begin
                countdown_a_next = secs_left(gs, phase_sec_next);
                countdown_b_next = secs_left(gs + ys, phase_sec_next);
            end
            else if (p == PH_B_GREEN)
            begin
                countdown_a_next = secs_left(gs + ys, phase_sec_next);
                countdown_b_next = secs_left(gs, phase_sec_next);
            end
            else if (p == PH_A_YELLOW || p == PH_B_YELLOW)
            begin
                countdown_a_next = secs_left(ys, phase_sec_next);
                countdown_b_next = countdown_a_next;
            end
        end

        phase_next       = p;
        phase_timer_next = t;
        night_flag_next  = nf;
        flash_flag_next  = ff;

        blink = !ff;
        out_data_next = '0;
        unique case (p)
            PH_A_GREEN:
            begin
                out_data_next.lamp_a_green = 1'b1;
                out_data_next.lamp_b_red   = 1'b1;
            end
            PH_A_YELLOW:
            begin
                out_data_next.lamp_a_yellow = blink;
                out_data_next.lamp_b_red    = 1'b1;
            end
            PH_B_GREEN:
            begin
                out_data_next.lamp_a_red   = 1'b1;
                out_data_next.lamp_b_green = 1'b1;
            end
            PH_B_YELLOW:
            begin
                out_data_next.lamp_a_red    = 1'b1;
                out_data_next.lamp_b_yellow = blink;
            end
            PH_EMERG:
            begin
                out_data_next.lamp_a_red = 1'b1;
                out_data_next.lamp_b_red = 1'b1;
            end
            default:
            begin
                out_data_next.lamp_a_yellow = blink;
                out_data_next.lamp_b_yellow = blink;
            end
        endcase
        out_data_next.seconds_left_a = countdown_a_next;
        out_data_next.seconds_left_b = countdown_b_next;
        out_data_next.display_blank  = (p == PH_EMERG || p == PH_NIGHT);
        out_data_next.buzzer_request = (p == PH_A_YELLOW || p == PH_B_YELLOW) && ff;
        out_data_next.phase          = p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_A_GREEN;
            phase_timer_reg  <= '0;
            phase_ms_reg     <= '0;
            phase_sec_reg    <= '0;
            flash_timer_reg  <= '0;
            sample_timer_reg <= '0;
            flash_flag_reg   <= 1'b0;
            night_flag_reg   <= 1'b0;
            countdown_a_reg  <= '0;
            countdown_b_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            phase_timer_reg  <= phase_timer_next;
            phase_ms_reg     <= phase_ms_next;
            phase_sec_reg    <= phase_sec_next;
            flash_timer_reg  <= flash_timer_next;
            sample_timer_reg <= sample_timer_next;
            flash_flag_reg   <= flash_flag_next;
            night_flag_reg   <= night_flag_next;
            countdown_a_reg  <= countdown_a_next;
            countdown_b_reg  <= countdown_b_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // second split tracks the phase timer
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(phase_sec_reg) * TICKS_PER_SECOND + 32'(phase_ms_reg)) == 32'(phase_timer_reg))
        else $error("phase second split out of step with phase timer");

    // at most one lamp per road
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({out_data.lamp_a_green, out_data.lamp_a_yellow,
                                out_data.lamp_a_red})
                   && $onehot0({out_data.lamp_b_green, out_data.lamp_b_yellow,
                                out_data.lamp_b_red}))
        else $error("conflicting lamps on one road");

    // an accepted beat is held in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted beat lost");

    // a stalled result keeps the input stage from advancing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

FILE: test/tb_top.sv
// testbench: traffic light controller checked beat by beat against a tick predictor
`timescale 1ns / 1ps

module tb_top;

    import tlc_pkg::*;

    localparam logic [KEY_W-1:0]     KEY_NONE  = 2'd0;
    localparam logic [KEY_W-1:0]     KEY_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [ADC_BITS-1:0]  LIGHT_MAX = '1;

    localparam int NUM_SETTINGS      = 6;
    localparam int TICKS_PER_SETTING = 105;
    localparam int STALL_LIMIT       = 1000;
    localparam int HOLD_CYCLES       = 120;
    localparam int HOLD_AFTER        = 300;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        tlc_in_t               tick;
        bit                    fixed;
        tlc_out_t              want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    tlc_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    tlc_out_t              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state and register copies
    logic [PHASE_W-1:0] cur_phase;
    int unsigned        phase_ms, flash_ms, sample_ms;
    bit                 flash_on, night_on;
    int unsigned        secs_a, secs_b;
    int unsigned        set_green, set_yellow, set_emerg, set_dark, set_sample, set_flash;

    plan_row_t   plan[$];
    tlc_out_t    pending_signals[$];
    int          mismatches  = 0;
    int          ticks_sent  = 0;
    int          beats_seen  = 0;
    int          writes_done = 0;
    int          phase_hits[8];
    bit          send_quiet  = 1'b0;

    traffic_light_controller_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_signals();
        cur_phase  = PH_A_GREEN;
        phase_ms   = 0;
        flash_ms   = 0;
        sample_ms  = 0;
        flash_on   = 1'b0;
        night_on   = 1'b0;
        secs_a     = 0;
        secs_b     = 0;
        set_green  = 7000;
        set_yellow = 3000;
        set_emerg  = 10000;
        set_dark   = 190;
        set_sample = 100;
        set_flash  = 500;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        unique case (idx)
            CFG_GREEN:     set_green  = 32'(value);
            CFG_YELLOW:    set_yellow = 32'(value);
            CFG_EMERGENCY: set_emerg  = 32'(value);
            CFG_DARK:      set_dark   = 32'(value[ADC_BITS-1:0]);
            CFG_SAMPLE:    set_sample = 32'(value[PERIOD_W-1:0]);
            CFG_FLASH:     set_flash  = 32'(value[PERIOD_W-1:0]);
            default:       ;
        endcase
    endfunction

    function automatic int unsigned secs_to_go(int unsigned total, int unsigned elapsed);
        int unsigned done_secs;
        int unsigned left;
        done_secs = elapsed / TICKS_PER_SECOND;
        left = (total > done_secs) ? total - done_secs : 0;
        return (left > 99) ? 99 : left;
    endfunction

    function automatic tlc_out_t advance_tick(tlc_in_t t);
        int unsigned gs;
        int unsigned ys;
        tlc_out_t    o;
        if (t.key_code == KEY_EMERGENCY)
            cur_phase = PH_EMERG;
        else if (t.key_code == KEY_NIGHT)
            cur_phase = PH_NIGHT;

        phase_ms  = (phase_ms + 1) & 32'hFFFF;
        flash_ms  = (flash_ms + 1) & 32'h3FF;
        sample_ms = (sample_ms + 1) & 32'h3FF;

        if (sample_ms >= set_sample)
        begin
            sample_ms = 0;
            night_on  = (32'(t.light_level) < set_dark);
            if (night_on && cur_phase != PH_NIGHT)
            begin
                cur_phase = PH_NIGHT;
                phase_ms  = 0;
            end
            else if (!night_on && cur_phase == PH_NIGHT)
            begin
                cur_phase = PH_A_GREEN;
                phase_ms  = 0;
            end
        end

        if (flash_ms >= set_flash)
        begin
            flash_ms = 0;
            flash_on = !flash_on;
        end

        if (!night_on)
        begin
            if (cur_phase == PH_A_GREEN && phase_ms >= set_green)
            begin
                phase_ms  = 0;
                cur_phase = PH_A_YELLOW;
            end
            if (cur_phase == PH_A_YELLOW && phase_ms >= set_yellow)
            begin
                phase_ms  = 0;
                cur_phase = PH_B_GREEN;
            end
            if (cur_phase == PH_B_GREEN && phase_ms >= set_green)
            begin
                phase_ms  = 0;
                cur_phase = PH_B_YELLOW;
            end
            if (cur_phase == PH_B_YELLOW && phase_ms >= set_yellow)
            begin
                phase_ms  = 0;
                cur_phase = PH_A_GREEN;
            end
        end

        if (cur_phase == PH_EMERG && phase_ms >= set_emerg)
        begin
            phase_ms  = 0;
            cur_phase = PH_A_GREEN;
        end

        if (phase_ms % TICKS_PER_SECOND == 1)
        begin
            gs = set_green / TICKS_PER_SECOND;
            ys = set_yellow / TICKS_PER_SECOND;
            unique case (cur_phase)
                PH_A_GREEN:
                begin
                    secs_a = secs_to_go(gs, phase_ms);
                    secs_b = secs_to_go(gs + ys, phase_ms);
                end
                PH_B_GREEN:
                begin
                    secs_a = secs_to_go(gs + ys, phase_ms);
                    secs_b = secs_to_go(gs, phase_ms);
                end
                PH_A_YELLOW, PH_B_YELLOW:
                begin
                    secs_a = secs_to_go(ys, phase_ms);
                    secs_b = secs_a;
                end
                default: ;
            endcase
        end

        o = '0;
        unique case (cur_phase)
            PH_A_GREEN:
            begin
                o.lamp_a_green = 1'b1;
                o.lamp_b_red   = 1'b1;
            end
            PH_A_YELLOW:
            begin
                o.lamp_a_yellow = !flash_on;
                o.lamp_b_red    = 1'b1;
            end
            PH_B_GREEN:
            begin
                o.lamp_a_red   = 1'b1;
                o.lamp_b_green = 1'b1;
            end
            PH_B_YELLOW:
            begin
                o.lamp_a_red    = 1'b1;
                o.lamp_b_yellow = !flash_on;
            end
            PH_EMERG:
            begin
                o.lamp_a_red = 1'b1;
                o.lamp_b_red = 1'b1;
            end
            default:
            begin
                o.lamp_a_yellow = !flash_on;
                o.lamp_b_yellow = !flash_on;
            end
        endcase
        o.seconds_left_a = secs_a[COUNT_W-1:0];
        o.seconds_left_b = secs_b[COUNT_W-1:0];
        o.display_blank  = (cur_phase == PH_EMERG || cur_phase == PH_NIGHT);
        o.buzzer_request = (cur_phase == PH_A_YELLOW || cur_phase == PH_B_YELLOW) && flash_on;
        o.phase          = cur_phase;
        return o;
    endfunction

    function automatic tlc_out_t fixed_out(logic ag, logic ay, logic ar, logic bg, logic by,
                                           logic br, int cda, int cdb, logic blank,
                                           logic [PHASE_W-1:0] ph);
        tlc_out_t o;
        o = '0;
        o.lamp_a_green   = ag;
        o.lamp_a_yellow  = ay;
        o.lamp_a_red     = ar;
        o.lamp_b_green   = bg;
        o.lamp_b_yellow  = by;
        o.lamp_b_red     = br;
        o.seconds_left_a = COUNT_W'(cda);
        o.seconds_left_b = COUNT_W'(cdb);
        o.display_blank  = blank;
        o.phase          = ph;
        return o;
    endfunction

    function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.value    = value;
        plan.push_back(row);
    endfunction

    function automatic void plan_tick(logic [KEY_W-1:0] key, logic [ADC_BITS-1:0] light,
                                      bit fixed = 1'b0, tlc_out_t want = '0);
        plan_row_t row;
        row = '{default: '0};
        row.tick.key_code    = key;
        row.tick.light_level = light;
        row.fixed            = fixed;
        row.want             = want;
        plan.push_back(row);
    endfunction

    function automatic int unsigned pick4(int unsigned a, int unsigned b, int unsigned c,
                                          int unsigned d);
        unique case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_setting(logic [CFG_IDX_W-1:0] idx);
        bit          extreme;
        int unsigned v;
        int unsigned width;
        extreme = ($urandom_range(0, 4) == 0);
        width   = CFG_DATA_W;
        case (idx)
            CFG_GREEN, CFG_YELLOW:
            begin
                v = extreme ? pick4(0, 1000, 60000, 65535) : $urandom_range(1, 40);
            end
            CFG_EMERGENCY:
            begin
                v = extreme ? pick4(0, 1000, 60000, 65535) : $urandom_range(5, 80);
            end
            CFG_DARK:
            begin
                v     = extreme ? pick4(0, 1, 4094, 4095) : $urandom_range(0, 4095);
                width = ADC_BITS;
            end
            default:
            begin
                v     = extreme ? pick4(0, 1, 1000, 1023) : $urandom_range(1, 30);
                width = PERIOD_W;
            end
        endcase
        // junk above a narrow register is dropped by the block
        if (width < CFG_DATA_W && $urandom_range(0, 7) == 0)
            v = v | ($urandom_range(1, (1 << (CFG_DATA_W - width)) - 1) << width);
        return v[CFG_DATA_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] draw_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 84)
            return KEY_NONE;
        else if (r < 91)
            return KEY_EMERGENCY;
        else if (r < 96)
            return KEY_NIGHT;
        else
            return KEY_SPARE;
    endfunction

    function automatic logic [ADC_BITS-1:0] draw_light(bit dusk);
        int unsigned sel;
        int unsigned v;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            if (dusk)
                v = (set_dark == 0) ? 0 : $urandom_range(0, set_dark - 1);
            else
                v = $urandom_range(set_dark, 4095);
        end
        else if (sel < 8)
            v = $urandom_range(0, 4095);
        else
        begin
            v = set_dark + $urandom_range(0, 2);
            v = (v == 0) ? 0 : v - 1;
            if (v > 4095)
                v = 4095;
        end
        return v[ADC_BITS-1:0];
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat(tlc_out_t want, tlc_out_t got);
        compare_field("lamp_a_green", want.lamp_a_green, got.lamp_a_green);
        compare_field("lamp_a_yellow", want.lamp_a_yellow, got.lamp_a_yellow);
        compare_field("lamp_a_red", want.lamp_a_red, got.lamp_a_red);
        compare_field("lamp_b_green", want.lamp_b_green, got.lamp_b_green);
        compare_field("lamp_b_yellow", want.lamp_b_yellow, got.lamp_b_yellow);
        compare_field("lamp_b_red", want.lamp_b_red, got.lamp_b_red);
        compare_field("seconds_left_a", want.seconds_left_a, got.seconds_left_a);
        compare_field("seconds_left_b", want.seconds_left_b, got.seconds_left_b);
        compare_field("display_blank", want.display_blank, got.display_blank);
        compare_field("buzzer_request", want.buzzer_request, got.buzzer_request);
        compare_field("phase", want.phase, got.phase);
    endtask

    task automatic send_tick(tlc_in_t t, bit fixed, tlc_out_t want);
        int       gap;
        tlc_out_t predicted;
        gap = send_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_tick(t);
        pending_signals.push_back(fixed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_signals.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_setting(idx, value);
        writes_done++;
    endtask

    // result side: random back-pressure, one long hold while ticks keep coming
    initial
    begin
        int       gap;
        bit       quiet;
        bit       hold_done;
        tlc_out_t want;
        quiet     = 1'b0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats_seen % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            gap = quiet ? 0 : $urandom_range(0, 14);
            if (!hold_done && beats_seen >= HOLD_AFTER && in_valid)
            begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            beats_seen++;
            phase_hits[out_data.phase]++;
            if (pending_signals.size() == 0)
            begin
                $error("result beat arrived with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_signals.pop_front();
                check_beat(want, out_data);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("traffic_light_controller_unit test failed");
        $finish;
    end

    initial
    begin
        plan_row_t row;
        tlc_in_t   t;
        bit        dusk;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        clear_signals();

        // after reset, default timing
        plan_tick(KEY_NONE, LIGHT_MAX, 1'b1,
                  fixed_out(1, 0, 0, 0, 0, 1, 7, 10, 0, PH_A_GREEN));
        plan_tick(KEY_EMERGENCY, LIGHT_MAX, 1'b1,
                  fixed_out(0, 0, 1, 0, 0, 1, 7, 10, 1, PH_EMERG));
        plan_tick(KEY_SPARE, '0, 1'b1,
                  fixed_out(0, 0, 1, 0, 0, 1, 7, 10, 1, PH_EMERG));
        plan_tick(KEY_EMERGENCY, '0, 1'b1,
                  fixed_out(0, 0, 1, 0, 0, 1, 7, 10, 1, PH_EMERG));
        plan_tick(KEY_NIGHT, LIGHT_MAX, 1'b1,
                  fixed_out(0, 1, 0, 0, 1, 0, 7, 10, 1, PH_NIGHT));
        // zero periods: sample and flash every tick
        plan_write(CFG_SAMPLE, '0);
        plan_write(CFG_FLASH, '0);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_write(CFG_DARK, 16'd4095);
        plan_tick(KEY_NONE, LIGHT_MAX - 1'b1);
        plan_tick(KEY_EMERGENCY, LIGHT_MAX - 1'b1);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_write(CFG_DARK, '0);
        plan_tick(KEY_NONE, '0);
        // zero phase lengths run the whole cycle in one tick
        plan_write(CFG_GREEN, '0);
        plan_write(CFG_YELLOW, '0);
        plan_tick(KEY_NONE, 12'd2048);
        // longest times: countdowns saturate
        plan_write(CFG_GREEN, 16'hFFFF);
        plan_write(CFG_YELLOW, 16'hFFFF);
        plan_write(CFG_EMERGENCY, 16'hFFFF);
        plan_tick(KEY_NIGHT, LIGHT_MAX);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_tick(KEY_EMERGENCY, LIGHT_MAX);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_write(CFG_SAMPLE, 16'd1023);
        plan_write(CFG_FLASH, 16'd1023);
        plan_write(CFG_EMERGENCY, 16'd1000);
        plan_write(CFG_DARK, 16'hF0BE);
        plan_write(CFG_SPARE_LO, 16'hA5A5);
        plan_write(CFG_SPARE_HI, 16'h5A5A);
        // short times so every phase turns over
        plan_write(CFG_GREEN, 16'd3);
        plan_write(CFG_YELLOW, 16'd2);
        plan_write(CFG_EMERGENCY, 16'd4);
        plan_write(CFG_SAMPLE, 16'd2);
        plan_write(CFG_FLASH, 16'd1);
        plan_tick(KEY_NONE, 12'd189);
        plan_tick(KEY_NONE, 12'd190);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_tick(KEY_NONE, LIGHT_MAX);
        plan_tick(KEY_EMERGENCY, LIGHT_MAX);
        plan_tick(KEY_EMERGENCY, LIGHT_MAX);
        plan_tick(KEY_NONE, '0);
        plan_tick(KEY_NONE, LIGHT_MAX);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_write)
                write_reg(row.idx, row.value);
            else
                send_tick(row.tick, row.fixed, row.want);
        end

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            for (int r = CFG_GREEN; r <= CFG_FLASH; r++)
                write_reg(CFG_IDX_W'(r), draw_setting(CFG_IDX_W'(r)));
            dusk = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < TICKS_PER_SETTING; n++)
            begin
                if (n % 50 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
                t.key_code    = draw_key();
                t.light_level = draw_light(dusk);
                send_tick(t, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_signals.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d tick beats sent, %0d result beats checked, %0d register writes",
                 ticks_sent, beats_seen, writes_done);
        $display("results by phase, A green through night: %0d %0d %0d %0d %0d %0d",
                 phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3],
                 phase_hits[4], phase_hits[5]);
        if (mismatches == 0)
            $display("traffic_light_controller_unit test passed");
        else
            $display("traffic_light_controller_unit test failed");
        $finish;
    end

endmodule
